// File: sv/mss_pkg.sv
package mss_pkg;

    localparam int STACK_DEPTH_DEFAULT = 256;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_LENGTH = 3'd4,
        OP_SEARCH = 3'd5,
        OP_REMOVE = 3'd6
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_SWEEP = 1'b1
    } t_state;

    typedef struct packed {
        logic [5:0] from_sq;
        logic [5:0] to_sq;
    } t_move;

    typedef struct packed {
        logic [2:0] opcode;
        logic [5:0] move_from;
        logic [5:0] move_to;
    } t_req;

    typedef struct packed {
        logic [5:0] out_from;
        logic [5:0] out_to;
        logic       found;
        logic [8:0] entry_count;
        logic [1:0] status;
    } t_rsp;

    typedef struct packed {
        logic  push;
        logic  pop;
        logic  remove;
        t_move key;
    } t_cell_ctl;

    typedef struct packed {
        t_move top_entry;
        logic  last_tok;
        logic  last_seen;
    } t_chain_sts;

endpackage

// File: sv/move_stack_with_search_remove.sv
// LIFO stack of moves (from and to squares) with search and remove.
// Request channel: i_req (opcode, move_from, move_to) is taken at a rising
// edge where start is high and busy is low.
// Result channel: o_rsp is valid for exactly one cycle while o_valid is high;
// the receiver cannot hold it off, so it must take it in that cycle.
// Storage is a chain of STACK_DEPTH cells, top of stack in the first cell.
// Push, pop, peek, clear and length shift the chain at most one place and
// return their result in the cycle after the request; busy stays low, so a
// new request may follow every cycle.
// Search and remove send a wave down the chain, one cell per cycle, that
// carries the match-seen flag; a cell at or below the topmost match takes its
// lower neighbor's entry on remove. Busy is high while the wave runs, and
// the result is registered once the wave reaches the last cell.
// Reset empties the stack and drops any wave; cell contents are not cleared
// and are only read below the entry count.
module move_stack_with_search_remove #(
    parameter int STACK_DEPTH = mss_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mss_pkg::t_req i_req,
    output logic          o_valid,
    output mss_pkg::t_rsp o_rsp
);
    import mss_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_cell_ctl     ctl;
    t_chain_sts    sts;
    logic [CW-1:0] count;
    logic          wave;
    t_move         entry [STACK_DEPTH];
    logic          tok   [STACK_DEPTH];
    logic          seen  [STACK_DEPTH];

    mss_ctrl #(
        .DEPTH (STACK_DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_count (count),
        .o_wave  (wave),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
        t_move above;
        t_move below;
        logic  tok_in;
        logic  seen_in;

        if (j == 0) begin : g_first
            assign above   = ctl.key;
            assign tok_in  = wave;
            assign seen_in = 1'b0;
        end else begin : g_mid
            assign above   = entry[j-1];
            assign tok_in  = tok[j-1];
            assign seen_in = seen[j-1];
        end

        if (j == STACK_DEPTH - 1) begin : g_last
            assign below = entry[j];
        end else begin : g_inner
            assign below = entry[j+1];
        end

        mss_cell #(
            .DEPTH (STACK_DEPTH),
            .IDX   (j),
            .CW    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_count (count),
            .i_above (above),
            .i_below (below),
            .i_tok   (tok_in),
            .i_seen  (seen_in),
            .o_entry (entry[j]),
            .o_tok   (tok[j]),
            .o_seen  (seen[j])
        );
    end

    assign sts.top_entry = entry[0];
    assign sts.last_tok  = tok[STACK_DEPTH-1];
    assign sts.last_seen = seen[STACK_DEPTH-1];

endmodule

// File: sv/mss_cell.sv
module mss_cell #(
    parameter int DEPTH = mss_pkg::STACK_DEPTH_DEFAULT,
    parameter int IDX   = 0,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mss_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]     i_count,
    input  mss_pkg::t_move    i_above,
    input  mss_pkg::t_move    i_below,
    input  logic              i_tok,
    input  logic              i_seen,
    output mss_pkg::t_move    o_entry,
    output logic              o_tok,
    output logic              o_seen
);
    import mss_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    t_move r_entry;
    logic  r_tok;
    logic  r_seen;
    logic  occupied;
    logic  hit;
    logic  seen;

    always_comb begin
        occupied = IDX_C < i_count;
        hit      = occupied && (r_entry == i_ctl.key);
        seen     = r_seen | hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_seen <= 1'b0;
        end else begin
            r_tok  <= i_tok;
            r_seen <= i_seen;
        end
    end

    // shift toward the bottom on push, toward the top on pop or when the wave removes
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_above;
        end else if (i_ctl.pop) begin
            r_entry <= i_below;
        end else if (r_tok && i_ctl.remove && seen) begin
            r_entry <= i_below;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;
    assign o_seen  = seen;

endmodule

// File: sv/mss_ctrl.sv
module mss_ctrl #(
    parameter int DEPTH = mss_pkg::STACK_DEPTH_DEFAULT,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  mss_pkg::t_req      i_req,
    input  mss_pkg::t_chain_sts i_sts,
    output mss_pkg::t_cell_ctl o_ctl,
    output logic [CW-1:0]      o_count,
    output logic               o_wave,
    output logic               o_valid,
    output mss_pkg::t_rsp      o_rsp
);
    import mss_pkg::*;

    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    t_move         r_key, n_key;
    logic          r_remove, n_remove;
    logic          r_valid, n_valid;
    t_rsp          r_rsp, n_rsp;
    logic          accept;
    t_move         req_key;
    logic [CW+8:0] cnt_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_remove <= n_remove;
        r_rsp    <= n_rsp;
    end

    always_comb begin
        accept          = start && (r_state == S_IDLE);
        req_key.from_sq = i_req.move_from;
        req_key.to_sq   = i_req.move_to;
        n_state         = r_state;
        n_count         = r_count;
        n_key           = r_key;
        n_remove        = r_remove;
        n_valid         = 1'b0;
        n_rsp           = '0;
        n_rsp.status    = ST_OK;
        o_wave          = 1'b0;
        o_ctl.push      = 1'b0;
        o_ctl.pop       = 1'b0;
        o_ctl.remove    = r_remove;
        o_ctl.key       = (r_state == S_SWEEP) ? r_key : req_key;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    case (i_req.opcode)
                        OP_PUSH: begin
                            if (r_count == FULL_C) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                o_ctl.push = 1'b1;
                                n_count    = r_count + CW'(1);
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_count == '0) begin
                                n_rsp.status = ST_EMPTY;
                            end else begin
                                n_rsp.out_from = i_sts.top_entry.from_sq;
                                n_rsp.out_to   = i_sts.top_entry.to_sq;
                                if (i_req.opcode == OP_POP) begin
                                    o_ctl.pop = 1'b1;
                                    n_count   = r_count - CW'(1);
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_SEARCH, OP_REMOVE: begin
                            n_valid  = 1'b0;
                            o_wave   = 1'b1;
                            n_key    = req_key;
                            n_remove = (i_req.opcode == OP_REMOVE);
                            n_state  = S_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                if (i_sts.last_tok) begin
                    n_valid     = 1'b1;
                    n_rsp.found = i_sts.last_seen;
                    if (r_remove && i_sts.last_seen) begin
                        n_count = r_count - CW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        cnt_ext           = {9'd0, n_count};
        n_rsp.entry_count = cnt_ext[8:0];
    end

    assign busy    = (r_state == S_SWEEP);
    assign o_count = r_count;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_C)
        else $error("entry count beyond depth");

    a_no_result_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !r_valid)
        else $error("result strobe during sweep");

    a_tok_only_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.last_tok |-> (r_state == S_SWEEP))
        else $error("wave outside sweep");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.opcode == OP_PUSH) && (r_count != FULL_C))
        |=> (r_count == $past(r_count) + CW'(1)) && r_valid)
        else $error("push did not grow stack");

    a_short_op_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.opcode != OP_SEARCH) && (i_req.opcode != OP_REMOVE))
        |=> r_valid && (r_state == S_IDLE))
        else $error("missing one cycle result");

endmodule
